// File: src/fss_pkg.sv
package fss_pkg;

    localparam int ANGLE_W    = 32;
    localparam int RATE_W     = 24;
    localparam int SHOT_W     = 19;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int PHASE_W    = 3;
    localparam int DIV_STEPS  = ANGLE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    // 0.3 rad/s in Q8.16, scaled by 5 so the test stays exact
    localparam logic [RATE_W+2:0] SLOW_LIMIT = 27'd98304;

    localparam logic [SHOT_W-1:0] RST_SHOT_ANGLE      = 19'd51472;
    localparam logic [THR_W-1:0]  RST_SINGLE_DONE_THR = 16'd3277;
    localparam logic [THR_W-1:0]  RST_CALI_DONE_THR   = 16'd3277;
    localparam logic [SHOT_W-1:0] RST_CALI_FWD_ANGLE  = 19'd25736;
    localparam logic [RATE_W-1:0] RST_CALI_REV_SPEED  = 24'hFB0000;
    localparam logic [THR_W-1:0]  RST_STALL_FRACTION  = 16'd32768;
    localparam logic [THR_W-1:0]  RST_STALL_TICKS     = 16'd1000;
    localparam logic [THR_W-1:0]  RST_SINGLE_TIMEOUT  = 16'd500;

    typedef enum logic [PHASE_W-1:0] {
        PH_READY  = 3'd0,
        PH_SINGLE = 3'd1,
        PH_CONT   = 3'd2,
        PH_CREV   = 3'd3,
        PH_CFWD   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHOT_ANGLE      = 4'd0,
        CFG_SINGLE_DONE_THR = 4'd1,
        CFG_CALI_DONE_THR   = 4'd2,
        CFG_CALI_FWD_ANGLE  = 4'd3,
        CFG_CALI_REV_SPEED  = 4'd4,
        CFG_STALL_FRACTION  = 4'd5,
        CFG_STALL_TICKS     = 4'd6,
        CFG_SINGLE_TIMEOUT  = 4'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] feeder_angle;
        logic [RATE_W-1:0]  feeder_rate;
        logic               trigger_button;
        logic               fire_hold;
        logic               force_stop;
        logic [RATE_W-1:0]  burst_speed;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] target_angle;
        logic [RATE_W-1:0]  target_rate;
        logic               speed_mode;
        logic               clear_pos_loop;
        logic               clear_rate_loop;
        logic [PHASE_W-1:0] phase;
        logic [ANGLE_W-1:0] shots_fired;
        logic               is_calibrated;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic [RATE_W-1:0] mag24(input logic [RATE_W-1:0] v);
        mag24 = v[RATE_W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [ANGLE_W-1:0] mag32(input logic [ANGLE_W-1:0] v);
        mag32 = v[ANGLE_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

// File: src/fss_if.sv
interface fss_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [fss_pkg::ANGLE_W-1:0] feeder_angle;
    logic signed [fss_pkg::RATE_W-1:0]  feeder_rate;
    logic                           trigger_button;
    logic                           fire_hold;
    logic                           force_stop;
    logic signed [fss_pkg::RATE_W-1:0]  burst_speed;

    modport source (output valid, feeder_angle, feeder_rate, trigger_button, fire_hold,
                    force_stop, burst_speed, input ready);
    modport sink (input valid, feeder_angle, feeder_rate, trigger_button, fire_hold,
                  force_stop, burst_speed, output ready);
endinterface

interface fss_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fss_pkg::ANGLE_W-1:0]  target_angle;
    logic signed [fss_pkg::RATE_W-1:0]   target_rate;
    logic                                speed_mode;
    logic                                clear_pos_loop;
    logic                                clear_rate_loop;
    logic [fss_pkg::PHASE_W-1:0]         phase;
    logic [fss_pkg::ANGLE_W-1:0]         shots_fired;
    logic                                is_calibrated;

    modport source (output valid, target_angle, target_rate, speed_mode, clear_pos_loop,
                    clear_rate_loop, phase, shots_fired, is_calibrated, input ready);
    modport sink (input valid, target_angle, target_rate, speed_mode, clear_pos_loop,
                  clear_rate_loop, phase, shots_fired, is_calibrated, output ready);
endinterface

interface fss_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fss_pkg::CFG_IDX_W-1:0]     index;
    logic [fss_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/fss_div.sv
module fss_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fss_pkg::ANGLE_W-1:0]   dividend,
    input  logic [fss_pkg::SHOT_W-1:0]    divisor,
    output logic                          done,
    output logic [fss_pkg::ANGLE_W-1:0]   quot,
    output logic [fss_pkg::SHOT_W-1:0]    rem
);
    // restoring divider, one quotient bit per cycle
    logic [fss_pkg::ANGLE_W-1:0]   quot_reg, quot_next;
    logic [fss_pkg::SHOT_W:0]      rem_reg, rem_next;
    logic [fss_pkg::SHOT_W-1:0]    dsr_reg, dsr_next;
    logic [fss_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [fss_pkg::SHOT_W:0]      trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg[fss_pkg::SHOT_W-1:0], quot_reg[fss_pkg::ANGLE_W-1]};
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = fss_pkg::DIV_CNT_W'(fss_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next  = trial - {1'b0, dsr_reg};
                quot_next = {quot_reg[fss_pkg::ANGLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[fss_pkg::ANGLE_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == fss_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign rem  = rem_reg[fss_pkg::SHOT_W-1:0];
endmodule

// File: src/fss_ctrl.sv
module fss_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fss_pkg::ctrl_sts_t sts,
    output fss_pkg::ctrl_cmd_t cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                    ready_next = 1'b0;
                end
            end
            S_START:  state_next = S_WAIT;
            S_WAIT:
            begin
                if (sts.div_done)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready      = ready_reg;
    assign cmd.load      = ready_reg && in_valid;
    assign cmd.div_start = (state_reg == S_START);
    assign cmd.commit    = (state_reg == S_COMMIT) && sts.out_free;
endmodule

// File: src/fss_dp.sv
module fss_dp #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  fss_pkg::ctrl_cmd_t              cmd,
    output logic                            out_free,
    input  fss_pkg::in_item_t               in_item,
    input  logic                            cfg_valid,
    input  logic [fss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [fss_pkg::ANGLE_W-1:0]     div_dividend,
    output logic [fss_pkg::SHOT_W-1:0]      div_divisor,
    input  logic [fss_pkg::ANGLE_W-1:0]     div_quot,
    input  logic [fss_pkg::SHOT_W-1:0]      div_rem,
    output logic                            out_valid,
    input  logic                            out_ready,
    output fss_pkg::out_item_t              out_item
);
    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > fss_pkg::THR_W) ? TW : fss_pkg::THR_W;
    localparam int AW = fss_pkg::ANGLE_W;
    localparam int RW = fss_pkg::RATE_W;

    // configuration
    logic [fss_pkg::SHOT_W-1:0] shot_angle_reg, cali_fwd_angle_reg;
    logic [fss_pkg::THR_W-1:0]  single_thr_reg, cali_thr_reg, stall_frac_reg;
    logic [fss_pkg::THR_W-1:0]  stall_ticks_reg, single_timeout_reg;
    logic [RW-1:0]              cali_rev_speed_reg;

    // sequencer state
    fss_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0]   goal_angle_reg, goal_angle_next;
    logic [RW-1:0]   goal_rate_reg, goal_rate_next;
    logic [AW-1:0]   stop_offset_reg, stop_offset_next;
    logic [AW-1:0]   last_shot_reg, last_shot_next;
    logic [AW-1:0]   shot_cnt_reg, shot_cnt_next;
    logic            cal_reg, cal_next;
    logic            resume_reg, resume_next;
    logic            trig_prev_reg, trig_prev_next;
    logic            armed_reg, armed_next;
    logic [TW-1:0]   stall_timer_reg, stall_timer_next;
    logic [TW-1:0]   single_timer_reg, single_timer_next;

    fss_pkg::in_item_t  in_reg;
    fss_pkg::out_item_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [AW-1:0]   cur, err, abs_err, d_val, rel;
    logic [RW-1:0]   rate, burst, abs_rate, abs_burst, abs_crs, mul_mag;
    logic [RW+2:0]   rate_x5;
    logic            slow;
    logic [39:0]     prod;
    logic [RW:0]     cont_diff, rev_diff, rev_mag;
    logic            stall_cond, st_hit, d_ok;
    logic [TW-1:0]   st_inc, single_inc;
    logic            go_en, clr_pos, clr_rate, speed;
    fss_pkg::phase_t go_tgt;

    assign cur       = in_reg.feeder_angle;
    assign rate      = in_reg.feeder_rate;
    assign burst     = in_reg.burst_speed;
    assign err       = goal_angle_reg - cur;
    assign abs_err   = fss_pkg::mag32(err);
    assign abs_rate  = fss_pkg::mag24(rate);
    assign abs_burst = fss_pkg::mag24(burst);
    assign abs_crs   = fss_pkg::mag24(cali_rev_speed_reg);
    assign rate_x5   = {1'b0, abs_rate, 2'b00} + {3'b000, abs_rate};
    assign slow      = rate_x5 < fss_pkg::SLOW_LIMIT;
    assign mul_mag   = (phase_reg == fss_pkg::PH_CONT) ? abs_burst : abs_crs;
    assign prod      = 40'(mul_mag) * 40'(stall_frac_reg);
    assign cont_diff = {1'b0, abs_burst} - {1'b0, abs_rate};
    assign rev_diff  = {rate[RW-1], rate} - {cali_rev_speed_reg[RW-1], cali_rev_speed_reg};
    assign rev_mag   = rev_diff[RW] ? (~rev_diff + 1'b1) : rev_diff;
    assign d_val     = cur - last_shot_reg;
    assign rel       = cur - stop_offset_reg;
    assign d_ok      = (shot_angle_reg != '0) && !d_val[AW-1]
                       && (d_val >= AW'(shot_angle_reg));
    assign st_inc     = (stall_timer_reg == '1) ? stall_timer_reg : stall_timer_reg + 1'b1;
    assign single_inc = (single_timer_reg == '1) ? single_timer_reg : single_timer_reg + 1'b1;

    assign div_dividend = (phase_reg == fss_pkg::PH_CFWD) ? fss_pkg::mag32(rel) : d_val;
    assign div_divisor  = shot_angle_reg;

    always_comb
    begin
        case (phase_reg)
            fss_pkg::PH_SINGLE:
                stall_cond = ({abs_err, 3'b000} > 35'(shot_angle_reg)) && slow;
            fss_pkg::PH_CONT:
                stall_cond = !cont_diff[RW] && (cont_diff != '0)
                             && ({cont_diff[RW-1:0], 16'h0000} > prod) && slow;
            fss_pkg::PH_CREV:
                stall_cond = {rev_mag, 16'h0000} > {1'b0, prod};
            default:
                stall_cond = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        goal_angle_next   = goal_angle_reg;
        goal_rate_next    = goal_rate_reg;
        stop_offset_next  = stop_offset_reg;
        last_shot_next    = last_shot_reg;
        shot_cnt_next     = shot_cnt_reg;
        cal_next          = cal_reg;
        resume_next       = resume_reg;
        trig_prev_next    = trig_prev_reg;
        armed_next        = armed_reg;
        stall_timer_next  = stall_timer_reg;
        single_timer_next = single_timer_reg;
        go_en             = 1'b0;
        go_tgt            = fss_pkg::PH_READY;
        clr_pos           = 1'b0;
        clr_rate          = 1'b0;
        st_hit            = 1'b0;

        // stall timer: first stalled tick arms, later ones count
        if (phase_reg == fss_pkg::PH_SINGLE || phase_reg == fss_pkg::PH_CREV
            || (phase_reg == fss_pkg::PH_CONT && in_reg.fire_hold))
        begin
            if (!stall_cond)
            begin
                armed_next       = 1'b0;
                stall_timer_next = '0;
            end
            else if (!armed_reg)
            begin
                armed_next       = 1'b1;
                stall_timer_next = '0;
            end
            else
            begin
                stall_timer_next = st_inc;
                st_hit           = CW'(st_inc) >= CW'(stall_ticks_reg);
            end
        end

        if (in_reg.force_stop && phase_reg != fss_pkg::PH_READY)
        begin
            go_en = 1'b1;
        end
        else
        begin
            case (phase_reg)
                fss_pkg::PH_READY:
                begin
                    trig_prev_next  = in_reg.trigger_button;
                    goal_angle_next = cur;
                    goal_rate_next  = '0;
                    if (in_reg.fire_hold)
                    begin
                        go_en  = 1'b1;
                        go_tgt = fss_pkg::PH_CONT;
                    end
                    else if (in_reg.trigger_button && !trig_prev_reg)
                    begin
                        go_en = 1'b1;
                        if (!cal_reg)
                        begin
                            resume_next = 1'b0;
                            go_tgt      = fss_pkg::PH_CREV;
                        end
                        else
                            go_tgt = fss_pkg::PH_SINGLE;
                    end
                end
                fss_pkg::PH_SINGLE:
                begin
                    single_timer_next = single_inc;
                    if (st_hit)
                    begin
                        resume_next = 1'b0;
                        go_en       = 1'b1;
                        go_tgt      = fss_pkg::PH_CREV;
                    end
                    else if (abs_err < AW'(single_thr_reg)
                             || CW'(single_inc) > CW'(single_timeout_reg))
                    begin
                        shot_cnt_next  = shot_cnt_reg + 1'b1;
                        last_shot_next = cur;
                        go_en          = 1'b1;
                        go_tgt         = fss_pkg::PH_DONE;
                    end
                end
                fss_pkg::PH_CONT:
                begin
                    if (!in_reg.fire_hold)
                    begin
                        go_en  = 1'b1;
                        go_tgt = fss_pkg::PH_DONE;
                    end
                    else
                    begin
                        goal_rate_next = burst;
                        if (d_ok)
                        begin
                            shot_cnt_next  = shot_cnt_reg + div_quot;
                            last_shot_next = cur - AW'(div_rem);
                        end
                        if (st_hit)
                        begin
                            resume_next = 1'b1;
                            go_en       = 1'b1;
                            go_tgt      = fss_pkg::PH_CREV;
                        end
                    end
                end
                fss_pkg::PH_CREV:
                begin
                    goal_rate_next = cali_rev_speed_reg;
                    if (st_hit)
                    begin
                        stop_offset_next = cur;
                        go_en            = 1'b1;
                        go_tgt           = fss_pkg::PH_CFWD;
                    end
                end
                fss_pkg::PH_CFWD:
                begin
                    if (abs_err < AW'(cali_thr_reg))
                    begin
                        cal_next = 1'b1;
                        // snap to the slot boundary at or toward the end stop
                        if (shot_angle_reg == '0)
                            goal_angle_next = stop_offset_reg;
                        else if (rel[AW-1])
                            goal_angle_next = cur + AW'(div_rem);
                        else
                            goal_angle_next = cur - AW'(div_rem);
                        go_en  = 1'b1;
                        go_tgt = resume_reg ? fss_pkg::PH_CONT : fss_pkg::PH_SINGLE;
                    end
                end
                fss_pkg::PH_DONE:
                    go_en = 1'b1;
                default:
                    go_en = 1'b1;
            endcase
        end

        if (go_en)
        begin
            armed_next       = 1'b0;
            stall_timer_next = '0;
            phase_next       = go_tgt;
            case (go_tgt)
                fss_pkg::PH_SINGLE:
                begin
                    clr_pos           = 1'b1;
                    clr_rate          = 1'b1;
                    goal_angle_next   = goal_angle_next + AW'(shot_angle_reg);
                    goal_rate_next    = '0;
                    single_timer_next = '0;
                end
                fss_pkg::PH_CONT:
                begin
                    cal_next = 1'b0;
                    if (phase_reg != fss_pkg::PH_CONT && phase_reg != fss_pkg::PH_CFWD)
                        clr_rate = 1'b1;
                    goal_rate_next = burst;
                end
                fss_pkg::PH_CREV:
                begin
                    clr_rate       = 1'b1;
                    goal_rate_next = cali_rev_speed_reg;
                end
                fss_pkg::PH_CFWD:
                begin
                    clr_pos         = 1'b1;
                    clr_rate        = 1'b1;
                    goal_angle_next = cur + AW'(cali_fwd_angle_reg);
                    goal_rate_next  = '0;
                end
                default:
                begin
                    clr_pos         = 1'b1;
                    clr_rate        = 1'b1;
                    goal_angle_next = cur;
                    goal_rate_next  = '0;
                end
            endcase
        end

        speed                    = (phase_next == fss_pkg::PH_CONT)
                                   || (phase_next == fss_pkg::PH_CREV);
        out_next.target_angle    = goal_angle_next;
        out_next.target_rate     = speed ? goal_rate_next : '0;
        out_next.speed_mode      = speed;
        out_next.clear_pos_loop  = clr_pos;
        out_next.clear_rate_loop = clr_rate;
        out_next.phase           = phase_next;
        out_next.shots_fired     = shot_cnt_next;
        out_next.is_calibrated   = cal_next;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shot_angle_reg     <= fss_pkg::RST_SHOT_ANGLE;
            single_thr_reg     <= fss_pkg::RST_SINGLE_DONE_THR;
            cali_thr_reg       <= fss_pkg::RST_CALI_DONE_THR;
            cali_fwd_angle_reg <= fss_pkg::RST_CALI_FWD_ANGLE;
            cali_rev_speed_reg <= fss_pkg::RST_CALI_REV_SPEED;
            stall_frac_reg     <= fss_pkg::RST_STALL_FRACTION;
            stall_ticks_reg    <= fss_pkg::RST_STALL_TICKS;
            single_timeout_reg <= fss_pkg::RST_SINGLE_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            case (fss_pkg::cfg_idx_t'(cfg_index))
                fss_pkg::CFG_SHOT_ANGLE:      shot_angle_reg <= cfg_data[fss_pkg::SHOT_W-1:0];
                fss_pkg::CFG_SINGLE_DONE_THR: single_thr_reg <= cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_CALI_DONE_THR:   cali_thr_reg <= cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_CALI_FWD_ANGLE:
                    cali_fwd_angle_reg <= cfg_data[fss_pkg::SHOT_W-1:0];
                fss_pkg::CFG_CALI_REV_SPEED:  cali_rev_speed_reg <= cfg_data[RW-1:0];
                fss_pkg::CFG_STALL_FRACTION:  stall_frac_reg <= cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_STALL_TICKS:     stall_ticks_reg <= cfg_data[fss_pkg::THR_W-1:0];
                fss_pkg::CFG_SINGLE_TIMEOUT:
                    single_timeout_reg <= cfg_data[fss_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= fss_pkg::PH_READY;
            goal_angle_reg   <= '0;
            goal_rate_reg    <= '0;
            stop_offset_reg  <= '0;
            last_shot_reg    <= '0;
            shot_cnt_reg     <= '0;
            cal_reg          <= 1'b0;
            resume_reg       <= 1'b0;
            trig_prev_reg    <= 1'b0;
            armed_reg        <= 1'b0;
            stall_timer_reg  <= '0;
            single_timer_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.commit)
            begin
                phase_reg        <= phase_next;
                goal_angle_reg   <= goal_angle_next;
                goal_rate_reg    <= goal_rate_next;
                stop_offset_reg  <= stop_offset_next;
                last_shot_reg    <= last_shot_next;
                shot_cnt_reg     <= shot_cnt_next;
                cal_reg          <= cal_next;
                resume_reg       <= resume_next;
                trig_prev_reg    <= trig_prev_next;
                armed_reg        <= armed_next;
                stall_timer_reg  <= stall_timer_next;
                single_timer_reg <= single_timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_item;
        if (cmd.commit)
            out_reg <= out_next;
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
endmodule

// File: src/feeder_shot_sequencer_top.sv
// Channel   Dir  Handshake      Carries
// req_in    in   valid/ready    feeder angle, rate, operator commands, burst speed
// rsp_out   out  valid/ready    targets, loop clear requests, phase, shot count
// cfg       in   valid/ready    register index and write data
//
// Each request runs from acceptance to a valid result in order: the divider is
// started, the bit-serial slot divider runs, then the result is committed.
// Reset (rst_n low, asynchronous) returns the sequencer to ready with state and
// configuration registers at defaults. A result waiting on rsp_out does not block
// the next request; only that request's commit waits for rsp_out to drain.
module feeder_shot_sequencer_top #(
    parameter int TIMER_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    fss_in_if.sink    req_in,
    fss_out_if.source rsp_out,
    fss_cfg_if.sink   cfg
);
    fss_pkg::ctrl_cmd_t cmd;
    fss_pkg::ctrl_sts_t sts;
    fss_pkg::in_item_t  in_item;
    fss_pkg::out_item_t out_item;

    logic [fss_pkg::ANGLE_W-1:0] div_dividend, div_quot;
    logic [fss_pkg::SHOT_W-1:0]  div_divisor, div_rem;
    logic                        out_free;

    // configuration writes land at once; the port never stalls
    assign cfg.ready = 1'b1;

    // pack the request fields for the datapath input latch
    assign in_item.feeder_angle   = req_in.feeder_angle;
    assign in_item.feeder_rate    = req_in.feeder_rate;
    assign in_item.trigger_button = req_in.trigger_button;
    assign in_item.fire_hold      = req_in.fire_hold;
    assign in_item.force_stop     = req_in.force_stop;
    assign in_item.burst_speed    = req_in.burst_speed;

    assign sts.out_free = out_free;

    // sequence one request: latch, start divider, wait, commit
    fss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_in.valid),
        .in_ready (req_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // remainder and quotient for slot alignment and continuous shot counting
    fss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (sts.div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    fss_dp #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .out_free     (out_free),
        .in_item      (in_item),
        .cfg_valid    (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quot     (div_quot),
        .div_rem      (div_rem),
        .out_valid    (rsp_out.valid),
        .out_ready    (rsp_out.ready),
        .out_item     (out_item)
    );

    // drive the result channel from the output register
    assign rsp_out.target_angle    = out_item.target_angle;
    assign rsp_out.target_rate     = out_item.target_rate;
    assign rsp_out.speed_mode      = out_item.speed_mode;
    assign rsp_out.clear_pos_loop  = out_item.clear_pos_loop;
    assign rsp_out.clear_rate_loop = out_item.clear_rate_loop;
    assign rsp_out.phase           = out_item.phase;
    assign rsp_out.shots_fired     = out_item.shots_fired;
    assign rsp_out.is_calibrated   = out_item.is_calibrated;

    // a commit never overwrites a result still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> sts.out_free)
        else $error("commit while output register is occupied");

    // a new result only appears after a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_out.valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_in.valid && req_in.ready) |=> !req_in.ready)
        else $error("second request accepted while busy");

    // divider start and done never coincide in consecutive cycles
    a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done)
        else $error("divider finished too early");
endmodule
